/* rtl/ira_pkg.sv */
`default_nettype none

package ira_pkg;

    localparam int unsigned DATA_W          = 64;
    localparam int unsigned DEF_VALUE_WIDTH = 64;
    localparam int unsigned MUL_STAGES      = 5;
    localparam int unsigned PIPE_STAGES     = MUL_STAGES + 3;

    typedef enum logic [2:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_UNION,
        K_INTERSECT,
        K_NARROW,
        K_CLASSIFY
    } kind_t;

    typedef enum logic [2:0] {
        CMP_LT,
        CMP_LE,
        CMP_GT,
        CMP_GE,
        CMP_EQ,
        CMP_NE
    } cmp_t;

    typedef enum logic [2:0] {
        TC_NONE,
        TC_U8,
        TC_U16,
        TC_U32,
        TC_I8,
        TC_I16,
        TC_I32
    } type_code_t;

    localparam logic signed [DATA_W-1:0] U8_TOP     = 64'sd255;
    localparam logic signed [DATA_W-1:0] U16_TOP    = 64'sd65535;
    localparam logic signed [DATA_W-1:0] U32_TOP    = 64'sd4294967295;
    localparam logic signed [DATA_W-1:0] S8_BOTTOM  = -64'sd128;
    localparam logic signed [DATA_W-1:0] S8_TOP     = 64'sd127;
    localparam logic signed [DATA_W-1:0] S16_BOTTOM = -64'sd32768;
    localparam logic signed [DATA_W-1:0] S16_TOP    = 64'sd32767;
    localparam logic signed [DATA_W-1:0] S32_BOTTOM = -64'sd2147483648;
    localparam logic signed [DATA_W-1:0] S32_TOP    = 64'sd2147483647;

endpackage

`default_nettype wire

/* rtl/ira_in_if.sv */
`default_nettype none

interface ira_in_if
    import ira_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] a_low;
    logic signed [DATA_W-1:0] a_high;
    logic                     a_unknown;
    logic signed [DATA_W-1:0] b_low;
    logic signed [DATA_W-1:0] b_high;
    logic                     b_unknown;
    logic [2:0]               compare_op;
    logic signed [DATA_W-1:0] bound_value;

    modport source (
        output valid, kind, a_low, a_high, a_unknown, b_low, b_high, b_unknown,
               compare_op, bound_value,
        input  ready
    );

    modport sink (
        input  valid, kind, a_low, a_high, a_unknown, b_low, b_high, b_unknown,
               compare_op, bound_value,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/ira_out_if.sv */
`default_nettype none

interface ira_out_if
    import ira_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] r_low;
    logic signed [DATA_W-1:0] r_high;
    logic                     r_unknown;
    logic signed [DATA_W-1:0] f_low;
    logic signed [DATA_W-1:0] f_high;
    logic                     f_unknown;
    logic [2:0]               type_code;

    modport source (
        output valid, r_low, r_high, r_unknown, f_low, f_high, f_unknown, type_code,
        input  ready
    );

    modport sink (
        input  valid, r_low, r_high, r_unknown, f_low, f_high, f_unknown, type_code,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/ira_corner_mul.sv */
`default_nettype none

module ira_corner_mul
    import ira_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic [MUL_STAGES-1:0]         en,
    input  logic signed [VALUE_WIDTH-1:0] x,
    input  logic signed [VALUE_WIDTH-1:0] y,
    output logic signed [VALUE_WIDTH-1:0] prod,
    output logic                          ovf
);

    localparam int unsigned W     = VALUE_WIDTH;
    localparam int unsigned LO_W  = (W + 1) / 2;
    localparam int unsigned HI_W  = W - LO_W;
    localparam int unsigned LL_W  = 2 * LO_W;
    localparam int unsigned HH_W  = 2 * HI_W;
    localparam int unsigned MID_W = W + 1;
    localparam int unsigned PW    = 2 * W;

    logic [W-1:0]            xm_reg, xm_next, ym_reg, ym_next;
    logic [MUL_STAGES-2:0]   neg_reg, neg_next;
    logic [LL_W-1:0]         ll_reg, ll_next;
    logic [W-1:0]            lh_reg, lh_next, hl_reg, hl_next;
    logic [HH_W-1:0]         hh_reg, hh_next;
    logic [MID_W-1:0]        mid_reg, mid_next;
    logic [PW-1:0]           lohi_reg, lohi_next, mag_reg, mag_next;
    logic [W-1:0]            mag_lo;
    logic                    neg_last;
    logic signed [W-1:0]     prod_reg, prod_next;
    logic                    ovf_reg, ovf_next;

    // magnitudes and product sign
    always_comb
    begin
        xm_next     = x[W-1] ? W'(-x) : W'(x);
        ym_next     = y[W-1] ? W'(-y) : W'(y);
        neg_next[0] = x[W-1] ^ y[W-1];
        for (int k = 1; k <= MUL_STAGES - 2; k++)
        begin
            neg_next[k] = neg_reg[k-1];
        end
    end

    // partial products, sums, sign and range check
    always_comb
    begin
        ll_next   = LL_W'(xm_reg[LO_W-1:0]) * LL_W'(ym_reg[LO_W-1:0]);
        lh_next   = W'(xm_reg[LO_W-1:0]) * W'(ym_reg[W-1:LO_W]);
        hl_next   = W'(xm_reg[W-1:LO_W]) * W'(ym_reg[LO_W-1:0]);
        hh_next   = HH_W'(xm_reg[W-1:LO_W]) * HH_W'(ym_reg[W-1:LO_W]);
        mid_next  = MID_W'(lh_reg) + MID_W'(hl_reg);
        lohi_next = {hh_reg, ll_reg};
        mag_next  = lohi_reg + (PW'(mid_reg) << LO_W);
        mag_lo    = mag_reg[W-1:0];
        neg_last  = neg_reg[MUL_STAGES-2];
        ovf_next  = (|mag_reg[PW-1:W])
                    || (neg_last ? (mag_lo[W-1] && (|mag_lo[W-2:0])) : mag_lo[W-1]);
        prod_next = neg_last ? -mag_lo : mag_lo;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xm_reg <= xm_next;
            ym_reg <= ym_next;
        end
        for (int k = 0; k <= MUL_STAGES - 2; k++)
        begin
            if (en[k])
            begin
                neg_reg[k] <= neg_next[k];
            end
        end
        if (en[1])
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (en[2])
        begin
            mid_reg  <= mid_next;
            lohi_reg <= lohi_next;
        end
        if (en[3])
        begin
            mag_reg <= mag_next;
        end
        if (en[4])
        begin
            prod_reg <= prod_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign prod = prod_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

/* rtl/interval_range_alu.sv */
// interval range alu: one range operation per transaction on the cmd channel,
// one result transaction on the rsp channel for each, in order.
// cmd carries the operation kind, ranges a and b with their unknown flags, and
// the comparison and bound used by narrow; rsp carries the result (or true
// branch), the false branch of narrow and the classify type code.
// only the low VALUE_WIDTH bits of each value are used, sign-extended; results
// are sign-extended back to 64 bits.
// each command passes through eight register stages, in order:
// input register, five multiplier stages (magnitudes, 32x32 partial products,
// middle sum, wide sum, sign and range check), corner min/max pairs, output
// register. the non-multiply results are formed in the first multiplier stage
// and ride alongside.
// one transaction per cycle is sustained while rsp accepts each result.
// each stage has its own valid bit; a stalled rsp holds the output register
// and the stages behind it fill their bubbles, so cmd.ready stays high until
// all eight stages hold a transaction while rsp is stalled.
// reset clears every valid bit: rsp.valid is low and cmd.ready high after it.
`default_nettype none

module interval_range_alu
    import ira_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ira_in_if.sink    cmd,
    ira_out_if.source rsp
);

    localparam int unsigned W       = VALUE_WIDTH;
    localparam int unsigned NSTG    = PIPE_STAGES;
    localparam int unsigned NCORNER = 4;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        logic                unk;
    } side_t;

    typedef struct packed {
        kind_t               kind;
        side_t               a;
        side_t               b;
        cmp_t                op;
        logic signed [W-1:0] c;
    } in_t;

    typedef struct packed {
        side_t      r;
        side_t      f;
        type_code_t tc;
        logic       is_mul;
    } res_t;

    logic [NSTG-1:0]     v_reg, v_next, en;
    in_t                 in_reg, in_next;
    res_t                res_next;
    res_t                res_pipe_reg [0:MUL_STAGES];
    res_t                out_reg, out_next, last;

    logic signed [W-1:0] alo, ahi, blo, bhi, c;
    logic signed [W-1:0] cx [NCORNER];
    logic signed [W-1:0] cy [NCORNER];
    logic signed [W-1:0] prod [NCORNER];
    logic [NCORNER-1:0]  povf;

    logic signed [W-1:0] lo01_reg, lo01_next, hi01_reg, hi01_next;
    logic signed [W-1:0] lo23_reg, lo23_next, hi23_reg, hi23_next;
    logic                ovf_any_reg, ovf_any_next;

    logic [W:0]          add_lo, add_hi, sub_lo, sub_hi;
    logic                add_ok, sub_ok, isect_empty;
    logic signed [W-1:0] ea_lo, ea_hi, cp1, cm1;
    logic                c_lt_lo, c_le_lo, c_gt_hi, c_ge_hi, a_inv, c_is_min, c_is_max;
    side_t               below_s, above_s, ge_s, le_s, pt_s, full_s;
    logic signed [DATA_W-1:0] lo64, hi64;
    type_code_t          cls_tc;

    function automatic cmp_t cmd_t_op(input logic [2:0] code);
        return cmp_t'(code);
    endfunction

    // handshake and stage enables
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || rsp.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? cmd.valid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign cmd.ready = en[0];

    // input register
    always_comb
    begin
        in_next.kind  = kind_t'(cmd.kind);
        in_next.a.lo  = cmd.a_low[W-1:0];
        in_next.a.hi  = cmd.a_high[W-1:0];
        in_next.a.unk = cmd.a_unknown;
        in_next.b.lo  = cmd.b_low[W-1:0];
        in_next.b.hi  = cmd.b_high[W-1:0];
        in_next.b.unk = cmd.b_unknown;
        in_next.op    = cmd_t_op(cmd.compare_op);
        in_next.c     = cmd.bound_value[W-1:0];
    end

    assign alo = in_reg.a.lo;
    assign ahi = in_reg.a.hi;
    assign blo = in_reg.b.lo;
    assign bhi = in_reg.b.hi;
    assign c   = in_reg.c;

    // add, sub, intersect
    always_comb
    begin
        add_lo      = {alo[W-1], alo} + {blo[W-1], blo};
        add_hi      = {ahi[W-1], ahi} + {bhi[W-1], bhi};
        sub_lo      = {alo[W-1], alo} - {bhi[W-1], bhi};
        sub_hi      = {ahi[W-1], ahi} - {blo[W-1], blo};
        add_ok      = (add_lo[W] == add_lo[W-1]) && (add_hi[W] == add_hi[W-1]);
        sub_ok      = (sub_lo[W] == sub_lo[W-1]) && (sub_hi[W] == sub_hi[W-1]);
        isect_empty = (alo > ahi) || (alo > bhi) || (blo > ahi) || (blo > bhi);
    end

    // narrow sides
    always_comb
    begin
        ea_lo    = in_reg.a.unk ? VMIN : alo;
        ea_hi    = in_reg.a.unk ? VMAX : ahi;
        cp1      = c + W'(1);
        cm1      = c - W'(1);
        c_lt_lo  = c < ea_lo;
        c_le_lo  = c <= ea_lo;
        c_gt_hi  = c > ea_hi;
        c_ge_hi  = c >= ea_hi;
        a_inv    = ea_lo > ea_hi;
        c_is_min = c == VMIN;
        c_is_max = c == VMAX;

        below_s.lo  = ea_lo;
        below_s.hi  = c_gt_hi ? ea_hi : cm1;
        below_s.unk = c_is_min || c_le_lo || a_inv;

        above_s.lo  = c_lt_lo ? ea_lo : cp1;
        above_s.hi  = ea_hi;
        above_s.unk = c_is_max || c_ge_hi || a_inv;

        ge_s.lo  = c_lt_lo ? ea_lo : c;
        ge_s.hi  = ea_hi;
        ge_s.unk = c_gt_hi || a_inv;

        le_s.lo  = ea_lo;
        le_s.hi  = c_gt_hi ? ea_hi : c;
        le_s.unk = c_lt_lo || a_inv;

        pt_s.lo  = c;
        pt_s.hi  = c;
        pt_s.unk = 1'b0;

        full_s.lo  = ea_lo;
        full_s.hi  = ea_hi;
        full_s.unk = a_inv;
    end

    // classify
    always_comb
    begin
        lo64 = DATA_W'(alo);
        hi64 = DATA_W'(ahi);
        if (in_reg.a.unk)
        begin
            cls_tc = TC_NONE;
        end
        else if (!lo64[DATA_W-1])
        begin
            if (hi64 <= U8_TOP)
                cls_tc = TC_U8;
            else if (hi64 <= U16_TOP)
                cls_tc = TC_U16;
            else if (hi64 <= U32_TOP)
                cls_tc = TC_U32;
            else
                cls_tc = TC_NONE;
        end
        else if (lo64 >= S8_BOTTOM && hi64 <= S8_TOP)
        begin
            cls_tc = TC_I8;
        end
        else if (lo64 >= S16_BOTTOM && hi64 <= S16_TOP)
        begin
            cls_tc = TC_I16;
        end
        else if (lo64 >= S32_BOTTOM && hi64 <= S32_TOP)
        begin
            cls_tc = TC_I32;
        end
        else
        begin
            cls_tc = TC_NONE;
        end
    end

    // operation stage result
    always_comb
    begin
        res_next       = '0;
        res_next.r.unk = 1'b1;
        case (in_reg.kind)
            K_ADD:
            begin
                if (!in_reg.a.unk && !in_reg.b.unk && add_ok)
                begin
                    res_next.r.lo  = add_lo[W-1:0];
                    res_next.r.hi  = add_hi[W-1:0];
                    res_next.r.unk = 1'b0;
                end
            end
            K_SUB:
            begin
                if (!in_reg.a.unk && !in_reg.b.unk && sub_ok)
                begin
                    res_next.r.lo  = sub_lo[W-1:0];
                    res_next.r.hi  = sub_hi[W-1:0];
                    res_next.r.unk = 1'b0;
                end
            end
            K_MUL:
            begin
                res_next.is_mul = 1'b1;
                res_next.r.unk  = in_reg.a.unk || in_reg.b.unk;
            end
            K_UNION:
            begin
                if (!in_reg.a.unk && !in_reg.b.unk)
                begin
                    res_next.r.lo  = (alo < blo) ? alo : blo;
                    res_next.r.hi  = (ahi > bhi) ? ahi : bhi;
                    res_next.r.unk = 1'b0;
                end
            end
            K_INTERSECT:
            begin
                if (in_reg.a.unk)
                begin
                    res_next.r = in_reg.b;
                end
                else if (in_reg.b.unk)
                begin
                    res_next.r = in_reg.a;
                end
                else if (!isect_empty)
                begin
                    res_next.r.lo  = (alo > blo) ? alo : blo;
                    res_next.r.hi  = (ahi < bhi) ? ahi : bhi;
                    res_next.r.unk = 1'b0;
                end
            end
            K_NARROW:
            begin
                case (in_reg.op)
                    CMP_LT:
                    begin
                        res_next.r = below_s;
                        res_next.f = ge_s;
                    end
                    CMP_LE:
                    begin
                        res_next.r = le_s;
                        res_next.f = above_s;
                    end
                    CMP_GT:
                    begin
                        res_next.r = above_s;
                        res_next.f = le_s;
                    end
                    CMP_GE:
                    begin
                        res_next.r = ge_s;
                        res_next.f = below_s;
                    end
                    CMP_EQ:
                    begin
                        res_next.r = pt_s;
                        res_next.f = full_s;
                    end
                    CMP_NE:
                    begin
                        res_next.r = full_s;
                        res_next.f = pt_s;
                    end
                    default:
                    begin
                        res_next.r.unk = 1'b1;
                        res_next.f.unk = 1'b1;
                    end
                endcase
            end
            K_CLASSIFY:
            begin
                res_next.r.unk = 1'b0;
                res_next.tc    = cls_tc;
            end
            default:
            begin
                res_next.r.unk = 1'b1;
            end
        endcase
        if (res_next.r.unk)
        begin
            res_next.r.lo = '0;
            res_next.r.hi = '0;
        end
        if (res_next.f.unk)
        begin
            res_next.f.lo = '0;
            res_next.f.hi = '0;
        end
    end

    // corner products
    always_comb
    begin
        cx[0] = alo;
        cy[0] = blo;
        cx[1] = alo;
        cy[1] = bhi;
        cx[2] = ahi;
        cy[2] = blo;
        cx[3] = ahi;
        cy[3] = bhi;
    end

    for (genvar g = 0; g < NCORNER; g++)
    begin : g_corner
        ira_corner_mul #(
            .VALUE_WIDTH (W)
        ) u_mul (
            .clk  (clk),
            .en   (en[MUL_STAGES:1]),
            .x    (cx[g]),
            .y    (cy[g]),
            .prod (prod[g]),
            .ovf  (povf[g])
        );
    end

    // pairwise min and max of the corners
    always_comb
    begin
        lo01_next    = (prod[0] < prod[1]) ? prod[0] : prod[1];
        hi01_next    = (prod[0] > prod[1]) ? prod[0] : prod[1];
        lo23_next    = (prod[2] < prod[3]) ? prod[2] : prod[3];
        hi23_next    = (prod[2] > prod[3]) ? prod[2] : prod[3];
        ovf_any_next = |povf;
    end

    // final select
    always_comb
    begin
        last = res_pipe_reg[MUL_STAGES];
        if (last.is_mul)
        begin
            out_next       = '0;
            out_next.r.unk = last.r.unk || ovf_any_reg;
            if (!out_next.r.unk)
            begin
                out_next.r.lo = (lo01_reg < lo23_reg) ? lo01_reg : lo23_reg;
                out_next.r.hi = (hi01_reg > hi23_reg) ? hi01_reg : hi23_reg;
            end
        end
        else
        begin
            out_next = last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            in_reg <= in_next;
        end
        if (en[1])
        begin
            res_pipe_reg[0] <= res_next;
        end
        for (int k = 1; k <= MUL_STAGES; k++)
        begin
            if (en[k+1])
            begin
                res_pipe_reg[k] <= res_pipe_reg[k-1];
            end
        end
        if (en[MUL_STAGES+1])
        begin
            lo01_reg    <= lo01_next;
            hi01_reg    <= hi01_next;
            lo23_reg    <= lo23_next;
            hi23_reg    <= hi23_next;
            ovf_any_reg <= ovf_any_next;
        end
        if (en[NSTG-1])
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid     = v_reg[NSTG-1];
    assign rsp.r_low     = DATA_W'(out_reg.r.lo);
    assign rsp.r_high    = DATA_W'(out_reg.r.hi);
    assign rsp.r_unknown = out_reg.r.unk;
    assign rsp.f_low     = DATA_W'(out_reg.f.lo);
    assign rsp.f_high    = DATA_W'(out_reg.f.hi);
    assign rsp.f_unknown = out_reg.f.unk;
    assign rsp.type_code = out_reg.tc;

    a_r_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.r_unknown |-> rsp.r_low == '0 && rsp.r_high == '0)
        else $error("unknown result with nonzero ends");

    a_f_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.f_unknown |-> rsp.f_low == '0 && rsp.f_high == '0)
        else $error("unknown false branch with nonzero ends");

    a_classify_known: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.type_code != TC_NONE |-> !rsp.r_unknown && !rsp.f_unknown)
        else $error("type code on an unknown result");

    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> &v_reg)
        else $error("cmd stalled while a stage is empty");

endmodule

`default_nettype wire

/* tb/interval_range_alu_test.sv */
module interval_range_alu_test;
    import ira_pkg::*;

    localparam int unsigned VW           = DEF_VALUE_WIDTH;
    localparam int unsigned RANDOM_ITEMS = 95;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned QUIET_LIMIT  = 2000;

    localparam int PHASE_GAP[4]   = '{0, 65, 0, 20};
    localparam int PHASE_STALL[4] = '{0, 0, 65, 20};

    localparam logic [2:0] K_RESERVED  = 3'd7;
    localparam logic [2:0] CMP_SPARE_A = 3'd6;
    localparam logic [2:0] CMP_SPARE_B = 3'd7;

    localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

    typedef logic signed [127:0] wide_t;

    localparam wide_t VAL_MAX = (wide_t'(1) <<< (VW - 1)) - 1;
    localparam wide_t VAL_MIN = -VAL_MAX - 1;

    typedef struct {
        logic [2:0]         kind;
        logic signed [63:0] a_low;
        logic signed [63:0] a_high;
        logic               a_unknown;
        logic signed [63:0] b_low;
        logic signed [63:0] b_high;
        logic               b_unknown;
        logic [2:0]         compare_op;
        logic signed [63:0] bound_value;
    } range_cmd_t;

    typedef struct {
        logic signed [63:0] r_low;
        logic signed [63:0] r_high;
        logic               r_unknown;
        logic signed [63:0] f_low;
        logic signed [63:0] f_high;
        logic               f_unknown;
        logic [2:0]         type_code;
    } range_rsp_t;

    typedef struct {
        range_cmd_t op;
        bit         typed;
        range_rsp_t want;
    } vector_t;

    typedef struct {
        wide_t lo;
        wide_t hi;
        bit    unk;
    } span_t;

    localparam range_rsp_t NO_CHECK = '{0, 0, 1'b0, 0, 0, 1'b0, TC_NONE};
    localparam range_rsp_t TOP_RSP  = '{0, 0, 1'b1, 0, 0, 1'b0, TC_NONE};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ira_in_if  cmd_bus ();
    ira_out_if rsp_bus ();

    bit         typed_flag;
    range_rsp_t typed_want;
    range_rsp_t expected_q[$];
    int         gap_pct    = 0;
    int         stall_pct  = 0;
    bit         hold_req   = 1'b0;
    int         mismatches = 0;

    vector_t directed_tbl[$] = '{
        '{'{K_ADD, 1, 2, 1'b0, 3, 4, 1'b0, CMP_LT, 0}, 1'b1,
          '{4, 6, 1'b0, 0, 0, 1'b0, TC_NONE}},
        '{'{K_ADD, S64_MAX, S64_MAX, 1'b0, 1, 1, 1'b0, CMP_LT, 0}, 1'b1, TOP_RSP},
        '{'{K_ADD, 5, 6, 1'b1, 1, 1, 1'b0, CMP_LT, 0}, 1'b1, TOP_RSP},
        '{'{K_SUB, S64_MIN, 0, 1'b0, 1, 1, 1'b0, CMP_LT, 0}, 1'b1, TOP_RSP},
        '{'{K_SUB, 10, 20, 1'b0, -5, 5, 1'b0, CMP_LT, 0}, 1'b0, NO_CHECK},
        '{'{K_MUL, -3, 4, 1'b0, -5, 6, 1'b0, CMP_LT, 0}, 1'b0, NO_CHECK},
        '{'{K_MUL, S64_MIN, S64_MIN, 1'b0, -1, -1, 1'b0, CMP_LT, 0}, 1'b1, TOP_RSP},
        '{'{K_MUL, S64_MIN, S64_MIN, 1'b0, 1, 1, 1'b0, CMP_LT, 0}, 1'b1,
          '{S64_MIN, S64_MIN, 1'b0, 0, 0, 1'b0, TC_NONE}},
        '{'{K_MUL, S32_BOTTOM, S32_TOP, 1'b0, S32_BOTTOM, U32_TOP, 1'b0, CMP_LT, 0},
          1'b0, NO_CHECK},
        '{'{K_UNION, S64_MIN, 0, 1'b0, 5, S64_MAX, 1'b0, CMP_LT, 0}, 1'b1,
          '{S64_MIN, S64_MAX, 1'b0, 0, 0, 1'b0, TC_NONE}},
        '{'{K_UNION, 1, 2, 1'b0, 3, 4, 1'b1, CMP_LT, 0}, 1'b1, TOP_RSP},
        '{'{K_INTERSECT, 0, 0, 1'b1, 5, -5, 1'b0, CMP_LT, 0}, 1'b1,
          '{5, -5, 1'b0, 0, 0, 1'b0, TC_NONE}},
        '{'{K_INTERSECT, 0, 10, 1'b0, 7, 8, 1'b1, CMP_LT, 0}, 1'b0, NO_CHECK},
        '{'{K_INTERSECT, 0, 1, 1'b0, 5, 6, 1'b0, CMP_LT, 0}, 1'b1, TOP_RSP},
        '{'{K_NARROW, 0, 0, 1'b1, 0, 0, 1'b0, CMP_LT, S64_MIN}, 1'b1,
          '{0, 0, 1'b1, S64_MIN, S64_MAX, 1'b0, TC_NONE}},
        '{'{K_NARROW, -7, 7, 1'b0, 0, 0, 1'b0, CMP_GT, S64_MAX}, 1'b0, NO_CHECK},
        '{'{K_NARROW, 0, 100, 1'b0, 0, 0, 1'b0, CMP_LE, 50}, 1'b0, NO_CHECK},
        '{'{K_NARROW, 0, 100, 1'b0, 0, 0, 1'b0, CMP_GE, 200}, 1'b0, NO_CHECK},
        '{'{K_NARROW, 10, -10, 1'b0, 0, 0, 1'b0, CMP_EQ, 3}, 1'b0, NO_CHECK},
        '{'{K_NARROW, 1, 9, 1'b0, 0, 0, 1'b0, CMP_NE, 5}, 1'b0, NO_CHECK},
        '{'{K_NARROW, 1, 9, 1'b0, 0, 0, 1'b0, CMP_SPARE_A, 5}, 1'b1,
          '{0, 0, 1'b1, 0, 0, 1'b1, TC_NONE}},
        '{'{K_NARROW, 0, 0, 1'b1, 0, 0, 1'b0, CMP_GE, S64_MIN}, 1'b0, NO_CHECK},
        '{'{K_CLASSIFY, 0, 255, 1'b0, 0, 0, 1'b0, CMP_LT, 0}, 1'b1,
          '{0, 0, 1'b0, 0, 0, 1'b0, TC_U8}},
        '{'{K_CLASSIFY, S32_BOTTOM, S32_TOP, 1'b0, 0, 0, 1'b0, CMP_LT, 0}, 1'b1,
          '{0, 0, 1'b0, 0, 0, 1'b0, TC_I32}},
        '{'{K_RESERVED, 3, 4, 1'b0, 5, 6, 1'b0, CMP_SPARE_B, 7}, 1'b1, TOP_RSP}
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    interval_range_alu u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    function automatic wide_t fold_value(logic [63:0] v);
        logic signed [63:0] s;
        s = $signed(v) <<< (64 - VW);
        s = s >>> (64 - VW);
        return wide_t'(s);
    endfunction

    function automatic span_t span_of(wide_t lo, wide_t hi);
        span_t s;
        s.lo  = lo;
        s.hi  = hi;
        s.unk = 1'b0;
        return s;
    endfunction

    function automatic span_t top_span();
        span_t s;
        s.lo  = 0;
        s.hi  = 0;
        s.unk = 1'b1;
        return s;
    endfunction

    function automatic span_t guard_empty(span_t s);
        if (!s.unk && s.lo > s.hi)
            return top_span();
        return s;
    endfunction

    function automatic bit in_range(wide_t v);
        return v >= VAL_MIN && v <= VAL_MAX;
    endfunction

    function automatic wide_t lesser(wide_t x, wide_t y);
        return x < y ? x : y;
    endfunction

    function automatic wide_t greater(wide_t x, wide_t y);
        return x > y ? x : y;
    endfunction

    function automatic span_t keep_below(span_t e, wide_t c);
        if (c == VAL_MIN)
            return top_span();
        return guard_empty(span_of(e.lo, lesser(c - 1, e.hi)));
    endfunction

    function automatic span_t keep_above(span_t e, wide_t c);
        if (c == VAL_MAX)
            return top_span();
        return guard_empty(span_of(greater(c + 1, e.lo), e.hi));
    endfunction

    function automatic range_rsp_t predict_range_op(range_cmd_t c);
        span_t      a, b, e, r, f;
        wide_t      bnd, lo, hi;
        wide_t      prod[4];
        bit         fits;
        range_rsp_t o;
        a     = span_of(fold_value(c.a_low), fold_value(c.a_high));
        a.unk = c.a_unknown;
        b     = span_of(fold_value(c.b_low), fold_value(c.b_high));
        b.unk = c.b_unknown;
        bnd   = fold_value(c.bound_value);
        r     = top_span();
        f     = span_of(0, 0);
        o.type_code = TC_NONE;
        case (c.kind)
            K_ADD:
            begin
                lo = a.lo + b.lo;
                hi = a.hi + b.hi;
                if (!a.unk && !b.unk && in_range(lo) && in_range(hi))
                    r = span_of(lo, hi);
            end
            K_SUB:
            begin
                lo = a.lo - b.hi;
                hi = a.hi - b.lo;
                if (!a.unk && !b.unk && in_range(lo) && in_range(hi))
                    r = span_of(lo, hi);
            end
            K_MUL:
            begin
                prod[0] = a.lo * b.lo;
                prod[1] = a.lo * b.hi;
                prod[2] = a.hi * b.lo;
                prod[3] = a.hi * b.hi;
                fits = !a.unk && !b.unk;
                lo   = prod[0];
                hi   = prod[0];
                for (int i = 0; i < 4; i++)
                begin
                    fits = fits && in_range(prod[i]);
                    lo   = lesser(lo, prod[i]);
                    hi   = greater(hi, prod[i]);
                end
                if (fits)
                    r = span_of(lo, hi);
            end
            K_UNION:
            begin
                if (!a.unk && !b.unk)
                    r = span_of(lesser(a.lo, b.lo), greater(a.hi, b.hi));
            end
            K_INTERSECT:
            begin
                if (a.unk)
                    r = b;
                else if (b.unk)
                    r = a;
                else
                    r = guard_empty(span_of(greater(a.lo, b.lo), lesser(a.hi, b.hi)));
            end
            K_NARROW:
            begin
                e = a.unk ? span_of(VAL_MIN, VAL_MAX) : a;
                case (c.compare_op)
                    CMP_LT:
                    begin
                        r = keep_below(e, bnd);
                        f = guard_empty(span_of(greater(bnd, e.lo), e.hi));
                    end
                    CMP_LE:
                    begin
                        r = guard_empty(span_of(e.lo, lesser(bnd, e.hi)));
                        f = keep_above(e, bnd);
                    end
                    CMP_GT:
                    begin
                        r = keep_above(e, bnd);
                        f = guard_empty(span_of(e.lo, lesser(bnd, e.hi)));
                    end
                    CMP_GE:
                    begin
                        r = guard_empty(span_of(greater(bnd, e.lo), e.hi));
                        f = keep_below(e, bnd);
                    end
                    CMP_EQ:
                    begin
                        r = span_of(bnd, bnd);
                        f = guard_empty(e);
                    end
                    CMP_NE:
                    begin
                        r = guard_empty(e);
                        f = span_of(bnd, bnd);
                    end
                    default:
                    begin
                        r = top_span();
                        f = top_span();
                    end
                endcase
            end
            K_CLASSIFY:
            begin
                r = span_of(0, 0);
                if (a.unk)
                    o.type_code = TC_NONE;
                else if (a.lo >= 0)
                begin
                    if (a.hi <= U8_TOP)
                        o.type_code = TC_U8;
                    else if (a.hi <= U16_TOP)
                        o.type_code = TC_U16;
                    else if (a.hi <= U32_TOP)
                        o.type_code = TC_U32;
                end
                else if (a.lo >= S8_BOTTOM && a.hi <= S8_TOP)
                    o.type_code = TC_I8;
                else if (a.lo >= S16_BOTTOM && a.hi <= S16_TOP)
                    o.type_code = TC_I16;
                else if (a.lo >= S32_BOTTOM && a.hi <= S32_TOP)
                    o.type_code = TC_I32;
            end
            default:
            begin
            end
        endcase
        o.r_low     = r.unk ? 64'd0 : r.lo[63:0];
        o.r_high    = r.unk ? 64'd0 : r.hi[63:0];
        o.r_unknown = r.unk;
        o.f_low     = f.unk ? 64'd0 : f.lo[63:0];
        o.f_high    = f.unk ? 64'd0 : f.hi[63:0];
        o.f_unknown = f.unk;
        return o;
    endfunction

    function automatic logic [63:0] rand_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: return S64_MIN + 64'($urandom_range(2));
            1: return S64_MAX - 64'($urandom_range(2));
            2: return 64'($urandom_range(2000)) - 64'd1000;
            3: return {$urandom, $urandom};
            4: return {{32{r[31]}}, r};
            5: return {{48{r[15]}}, r[15:0]};
            6: return 64'(r[8:0]);
            default: return $signed({r, $urandom}) >>> $urandom_range(63);
        endcase
    endfunction

    task automatic offer_cmd(input range_cmd_t c, input bit typed, input range_rsp_t want);
        while ($urandom_range(99) < gap_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.kind        <= c.kind;
        cmd_bus.a_low       <= c.a_low;
        cmd_bus.a_high      <= c.a_high;
        cmd_bus.a_unknown   <= c.a_unknown;
        cmd_bus.b_low       <= c.b_low;
        cmd_bus.b_high      <= c.b_high;
        cmd_bus.b_unknown   <= c.b_unknown;
        cmd_bus.compare_op  <= c.compare_op;
        cmd_bus.bound_value <= c.bound_value;
        typed_flag          <= typed;
        typed_want          <= want;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        range_cmd_t seen;
        range_rsp_t got, want;
        if (rst_n)
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                seen = '{cmd_bus.kind, cmd_bus.a_low, cmd_bus.a_high, cmd_bus.a_unknown,
                         cmd_bus.b_low, cmd_bus.b_high, cmd_bus.b_unknown,
                         cmd_bus.compare_op, cmd_bus.bound_value};
                if (typed_flag)
                    expected_q.push_back(typed_want);
                else
                    expected_q.push_back(predict_range_op(seen));
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got = '{rsp_bus.r_low, rsp_bus.r_high, rsp_bus.r_unknown, rsp_bus.f_low,
                        rsp_bus.f_high, rsp_bus.f_unknown, rsp_bus.type_code};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, r_low %0h r_high %0h",
                             $time, got.r_low, got.r_high);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("r_low", want.r_low, got.r_low);
                    compare_field("r_high", want.r_high, got.r_high);
                    compare_field("r_unknown", 64'(want.r_unknown), 64'(got.r_unknown));
                    compare_field("f_low", want.f_low, got.f_low);
                    compare_field("f_high", want.f_high, got.f_high);
                    compare_field("f_unknown", 64'(want.f_unknown), 64'(got.f_unknown));
                    compare_field("type_code", 64'(want.type_code), 64'(got.type_code));
                end
            end
        end
    end

    initial
    begin : receiver
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("interval_range_alu test failed");
        $finish;
    end

    initial
    begin : stimulus
        range_cmd_t  c;
        logic [63:0] t;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.kind        <= K_ADD;
        cmd_bus.a_low       <= '0;
        cmd_bus.a_high      <= '0;
        cmd_bus.a_unknown   <= 1'b0;
        cmd_bus.b_low       <= '0;
        cmd_bus.b_high      <= '0;
        cmd_bus.b_unknown   <= 1'b0;
        cmd_bus.compare_op  <= CMP_LT;
        cmd_bus.bound_value <= '0;
        typed_flag          <= 1'b0;
        typed_want          <= NO_CHECK;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tbl[i])
            offer_cmd(directed_tbl[i].op, directed_tbl[i].typed, directed_tbl[i].want);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct   = PHASE_GAP[ph];
            stall_pct = PHASE_STALL[ph];
            // long output stall so the pipeline fills and backs up
            if (ph == 0)
                hold_req = 1'b1;
            repeat (RANDOM_ITEMS)
            begin
                if ($urandom_range(99) < 4)
                    c.kind = K_RESERVED;
                else
                    c.kind = 3'($urandom_range(int'(K_CLASSIFY)));
                c.a_low  = rand_value();
                c.a_high = rand_value();
                if ($urandom_range(99) < 85 && c.a_low > c.a_high)
                begin
                    t        = c.a_low;
                    c.a_low  = c.a_high;
                    c.a_high = t;
                end
                c.b_low  = rand_value();
                c.b_high = rand_value();
                if ($urandom_range(99) < 85 && c.b_low > c.b_high)
                begin
                    t        = c.b_low;
                    c.b_low  = c.b_high;
                    c.b_high = t;
                end
                c.a_unknown = ($urandom_range(99) < 12);
                c.b_unknown = ($urandom_range(99) < 12);
                if ($urandom_range(99) < 6)
                    c.compare_op = $urandom_range(1) ? CMP_SPARE_A : CMP_SPARE_B;
                else
                    c.compare_op = 3'($urandom_range(int'(CMP_NE)));
                case ($urandom_range(5))
                    0: c.bound_value = c.a_low;
                    1: c.bound_value = c.a_high;
                    2: c.bound_value = c.a_low - 64'd1;
                    3: c.bound_value = c.a_high + 64'd1;
                    default: c.bound_value = rand_value();
                endcase
                offer_cmd(c, 1'b0, NO_CHECK);
            end
            drain_results();
        end

        repeat (2 * PIPE_STAGES) @(posedge clk);
        if (mismatches == 0)
            $display("interval_range_alu test passed");
        else
            $display("interval_range_alu test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/ira_pkg.sv
rtl/ira_in_if.sv
rtl/ira_out_if.sv
rtl/ira_corner_mul.sv
rtl/interval_range_alu.sv
tb/interval_range_alu_test.sv
